// ----- sv/rtovs_pkg.sv -----
// rtovs_pkg: shared types and constants for the rectangle table hit-test block
// holds the item and result transaction structs, command codes and defaults
// no dependencies
`default_nettype none

package rtovs_pkg;

    // default sizing handed to the top level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;

    // field widths fixed by the interface
    localparam int FIELD_W  = 16;
    localparam int CFG_W    = 5;
    localparam int CMD_W    = 2;
    localparam int EIDX_W   = 4;
    localparam int MIDX_W   = 4;
    localparam int SCORE_W  = 17;

    // score saturation point
    localparam int SCORE_MAX = 131071;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OVERLAP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POINT   = 2'd2;

    // input transaction
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [EIDX_W-1:0]         entry_index;
        logic signed [FIELD_W-1:0] rect_left;
        logic signed [FIELD_W-1:0] rect_top;
        logic signed [FIELD_W-1:0] rect_right;
        logic signed [FIELD_W-1:0] rect_bottom;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
    } item_t;

    // result transaction
    typedef struct packed {
        logic                found;
        logic [MIDX_W-1:0]   match_index;
        logic [SCORE_W-1:0]  best_score;
    } result_t;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- sv/rect_table_overlap_select.sv -----
// A write, an unused command or a query with nothing to search goes straight to the
// done step; any other query reads the searched entries, one table read a cycle, then
// clips, scores and finishes. One transaction at a time: the input stalls after each
// accepted item until its result is registered, longer while an earlier result waits.
// Reset: rst_n clears the sequencer, the searched-entry count and the output valid;
// the rectangle table has no reset and must be written before it is searched.
// top level: rectangle table with best-overlap and point hit-test queries
// depends on rtovs_pkg
`default_nettype none

module rect_table_overlap_select
    import rtovs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item channel
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    // result channel
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result,
    // configuration write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W = 4 * CB;

    // handshakes
    logic item_accept;
    logic result_take;

    // sequencer and configuration
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   count_reg;
    logic [CNT_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   last_c;

    // scan control
    logic               issuing_reg, issuing_next;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               rdv_reg, rdv_next;
    logic               s1v_reg, s1v_next;

    // table memory and read stage
    logic [ROW_W-1:0]   mem [MAX_ENTRIES];
    logic [ROW_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    // latched query
    logic [CMD_W-1:0]   cmd_reg;
    logic signed [CB-1:0] q_x1_reg, q_y1_reg, q_x2_reg, q_y2_reg, px_reg, py_reg;

    // converted input coordinates
    logic signed [CB-1:0] in_x1, in_y1, in_x2, in_y2, in_px, in_py;
    logic [IDX_W-1:0]     wr_addr;
    logic                 wr_in_range;

    // stage 1: intersection extents and point test
    logic signed [CB-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [CB-1:0] ix1, iy1, ix2, iy2;
    logic signed [CB:0]   dx_c, dy_c;
    logic                 hit_c;
    logic signed [CB:0]   dx_reg, dy_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     s1_idx_reg;

    // stage 2: score and selection
    logic [CB:0]          sum_c;
    logic [SCORE_W-1:0]   score_c;
    logic                 pos_c;
    logic                 found_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SCORE_W-1:0]   best_reg;

    // output register
    logic                 result_valid_reg;
    result_t              result_reg;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_take  = result_valid_reg && !result_stall;
    assign cfg_ready    = 1'b1;

    // coordinates wrapped to the internal width
    assign in_x1 = CB'(item.rect_left);
    assign in_y1 = CB'(item.rect_top);
    assign in_x2 = CB'(item.rect_right);
    assign in_y2 = CB'(item.rect_bottom);
    assign in_px = CB'(item.point_x);
    assign in_py = CB'(item.point_y);

    assign wr_addr     = IDX_W'(item.entry_index);
    assign wr_in_range = (32'(item.entry_index) < MAX_ENTRIES);

    // searched entry count, saturated at table size
    always_comb
    begin
        if (32'(count_reg) > MAX_ENTRIES)
            n_cnt = CNT_W'(MAX_ENTRIES);
        else
            n_cnt = CNT_W'(count_reg);
        last_c = IDX_W'(n_cnt - CNT_W'(1));
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (item_accept && item.cmd == CMD_WRITE && wr_in_range)
            mem[wr_addr] <= {in_x1, in_y1, in_x2, in_y2};
    end

    // table read port, one entry per cycle during the scan
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && issuing_reg)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        issuing_next = issuing_reg;
        rdv_next     = 1'b0;
        s1v_next     = rdv_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if ((item.cmd == CMD_OVERLAP || item.cmd == CMD_POINT) && n_cnt != '0)
                    begin
                        state_next   = S_SCAN;
                        issuing_next = 1'b1;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (issuing_reg)
                begin
                    rdv_next = 1'b1;
                    if (addr_reg == last_reg)
                        issuing_next = 1'b0;
                end
                else if (!rdv_reg && !s1v_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next   = S_IDLE;
                issuing_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issuing_reg <= 1'b0;
            rdv_reg     <= 1'b0;
            s1v_reg     <= 1'b0;
            addr_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            rdv_reg     <= rdv_next;
            s1v_reg     <= s1v_next;
            if (item_accept)
                addr_reg <= '0;
            else if (state_reg == S_SCAN && issuing_reg)
                addr_reg <= addr_reg + IDX_W'(1);
        end
    end

    // latch the query on acceptance
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            cmd_reg  <= item.cmd;
            q_x1_reg <= in_x1;
            q_y1_reg <= in_y1;
            q_x2_reg <= in_x2;
            q_y2_reg <= in_y2;
            px_reg   <= in_px;
            py_reg   <= in_py;
            last_reg <= last_c;
        end
    end

    // stage 1: clip entry against query, test point
    always_comb
    begin
        r_x1 = rd_data_reg[4*CB-1 -: CB];
        r_y1 = rd_data_reg[3*CB-1 -: CB];
        r_x2 = rd_data_reg[2*CB-1 -: CB];
        r_y2 = rd_data_reg[CB-1 -: CB];
        ix1  = (r_x1 > q_x1_reg) ? r_x1 : q_x1_reg;
        iy1  = (r_y1 > q_y1_reg) ? r_y1 : q_y1_reg;
        ix2  = (r_x2 < q_x2_reg) ? r_x2 : q_x2_reg;
        iy2  = (r_y2 < q_y2_reg) ? r_y2 : q_y2_reg;
        dx_c = (CB+1)'(ix2) - (CB+1)'(ix1);
        dy_c = (CB+1)'(iy2) - (CB+1)'(iy1);
        hit_c = (r_x1 <= px_reg) && (px_reg < r_x2) && (r_y1 <= py_reg) && (py_reg < r_y2);
    end

    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            dx_reg     <= dx_c;
            dy_reg     <= dy_c;
            hit_reg    <= hit_c;
            s1_idx_reg <= rd_idx_reg;
        end
    end

    // stage 2: score with saturation
    always_comb
    begin
        pos_c = !dx_reg[CB] && (dx_reg != '0) && !dy_reg[CB] && (dy_reg != '0);
        sum_c = {1'b0, dx_reg[CB-1:0]} + {1'b0, dy_reg[CB-1:0]};
        if (33'(sum_c) > 33'(SCORE_MAX))
            score_c = SCORE_W'(SCORE_MAX);
        else
            score_c = SCORE_W'(sum_c);
    end

    // running selection, cleared per transaction
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= '0;
        end
        else if (s1v_reg)
        begin
            if (cmd_reg == CMD_OVERLAP)
            begin
                if (pos_c && score_c > best_reg)
                begin
                    found_reg <= 1'b1;
                    idx_reg   <= s1_idx_reg;
                    best_reg  <= score_c;
                end
            end
            else if (hit_reg && !found_reg)
            begin
                found_reg <= 1'b1;
                idx_reg   <= s1_idx_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && (!result_valid_reg || result_take))
            result_valid_reg <= 1'b1;
        else if (result_take)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!result_valid_reg || result_take))
        begin
            result_reg.found       <= found_reg;
            result_reg.match_index <= MIDX_W'(idx_reg);
            result_reg.best_score  <= best_reg;
        end
    end

endmodule

`default_nettype wire

// ----- verif/rtovs_checker.sv -----
// rtovs_checker: watches the item, result and configuration channels of the
// rectangle table block, predicts every result and compares it field by field
// depends on rtovs_pkg
`timescale 1ns / 1ps

module rtovs_checker
    import rtovs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  item_t            item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  result_t          result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               checked
);

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

    typedef struct {
        logic signed [FIELD_W-1:0] left;
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] right;
        logic signed [FIELD_W-1:0] bottom;
    } rect_t;

    // shadow of the table and the search count
    rect_t       rect_copy [TABLE_DEPTH];
    int          search_span = 0;
    result_t     awaited_results[$];
    int          mismatches = 0;
    int          compared = 0;

    assign errors  = mismatches;
    assign checked = compared;

    // expected result of one item against the current table
    function automatic result_t hit_test(item_t it);
        result_t res;
        int      i;
        int      ix1, iy1, ix2, iy2;
        int      score, best;
        int      px, py;
        res  = '0;
        best = 0;
        px   = it.point_x;
        py   = it.point_y;
        if (it.cmd == CMD_OVERLAP)
        begin
            for (i = 0; i < search_span; i++)
            begin
                ix1 = (rect_copy[i].left > it.rect_left) ? rect_copy[i].left : it.rect_left;
                iy1 = (rect_copy[i].top > it.rect_top) ? rect_copy[i].top : it.rect_top;
                ix2 = (rect_copy[i].right < it.rect_right) ? rect_copy[i].right
                                                            : it.rect_right;
                iy2 = (rect_copy[i].bottom < it.rect_bottom) ? rect_copy[i].bottom
                                                              : it.rect_bottom;
                if (ix2 > ix1 && iy2 > iy1)
                begin
                    score = (ix2 - ix1) + (iy2 - iy1);
                    if (score > SCORE_MAX)
                        score = SCORE_MAX;
                    // first entry with the strictly largest score wins
                    if (score > best)
                    begin
                        best            = score;
                        res.found       = 1'b1;
                        res.match_index = i[MIDX_W-1:0];
                        res.best_score  = best[SCORE_W-1:0];
                    end
                end
            end
        end
        else if (it.cmd == CMD_POINT)
        begin
            for (i = 0; i < search_span; i++)
            begin
                if (!res.found && px >= rect_copy[i].left && px < rect_copy[i].right
                        && py >= rect_copy[i].top && py < rect_copy[i].bottom)
                begin
                    res.found       = 1'b1;
                    res.match_index = i[MIDX_W-1:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input result_t want, input result_t got);
        if (mismatches < 10)
            $display("%0t: %s: expected found=%0d index=%0d score=%0d, %s=%0d index=%0d score=%0d",
                     $time, what, want.found, want.match_index, want.best_score,
                     "got found", got.found, got.match_index, got.best_score);
        mismatches++;
    endtask

    // per-edge channel monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            // result transaction: compare with the oldest expectation
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report("result with nothing outstanding", '0, result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compared++;
                    if (result.found !== want.found || result.match_index !== want.match_index
                            || result.best_score !== want.best_score)
                        report("result mismatch", want, result);
                end
            end
            // item transaction: predict, then apply a table write
            if (item_valid && !item_stall)
            begin
                awaited_results.push_back(hit_test(item));
                if (item.cmd == CMD_WRITE)
                begin
                    rect_copy[item.entry_index].left   = item.rect_left;
                    rect_copy[item.entry_index].top    = item.rect_top;
                    rect_copy[item.entry_index].right  = item.rect_right;
                    rect_copy[item.entry_index].bottom = item.rect_bottom;
                end
            end
            // search count write, saturating at the table size
            if (cfg_valid && cfg_ready)
                search_span = (int'(cfg_data) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_data);
            pending <= awaited_results.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// tb: stimulus and verdict for the rectangle table hit-test block
// depends on rtovs_pkg, rect_table_overlap_select and rtovs_checker
`timescale 1ns / 1ps

module tb;
    import rtovs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               PHASE_ITEMS = 125;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data     = '0;

    int errors;
    int pending;
    int checked;

    int burst_left   = 1;
    int n_writes     = 0;
    int n_overlap    = 0;
    int n_point      = 0;
    int n_unused     = 0;
    int n_settings   = 0;

    rect_table_overlap_select DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    rtovs_checker results_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // coordinate mostly near the origin, sometimes anywhere, sometimes at an extreme
    function automatic logic signed [FIELD_W-1:0] pick_coord();
        int v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = int'($urandom_range(0, 400)) - 200;
        else if (sel < 85)
            v = $urandom;
        else
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                default: v = -1;
            endcase
        return v[FIELD_W-1:0];
    endfunction

    function automatic item_t rect_item(input logic [CMD_W-1:0] op, input int idx,
                                        input int l, input int t, input int r, input int b);
        item_t x;
        x             = '0;
        x.cmd         = op;
        x.entry_index = idx[EIDX_W-1:0];
        x.rect_left   = l[FIELD_W-1:0];
        x.rect_top    = t[FIELD_W-1:0];
        x.rect_right  = r[FIELD_W-1:0];
        x.rect_bottom = b[FIELD_W-1:0];
        return x;
    endfunction

    function automatic item_t point_item(input int px, input int py);
        item_t x;
        x         = '0;
        x.cmd     = CMD_POINT;
        x.point_x = px[FIELD_W-1:0];
        x.point_y = py[FIELD_W-1:0];
        return x;
    endfunction

    // random transaction, every field filled whatever the command
    function automatic item_t random_item();
        item_t x;
        int    sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            x.cmd = CMD_WRITE;
        else if (sel < 60)
            x.cmd = CMD_OVERLAP;
        else if (sel < 94)
            x.cmd = CMD_POINT;
        else
            x.cmd = CMD_UNUSED;
        x.entry_index = EIDX_W'($urandom);
        x.rect_left   = pick_coord();
        x.rect_top    = pick_coord();
        // mostly ordered rectangles of modest size, some arbitrary or inverted
        if ($urandom_range(0, 9) == 0)
            x.rect_right = pick_coord();
        else
            x.rect_right = x.rect_left + FIELD_W'($urandom_range(0, 120));
        if ($urandom_range(0, 9) == 0)
            x.rect_bottom = pick_coord();
        else
            x.rect_bottom = x.rect_top + FIELD_W'($urandom_range(0, 120));
        x.point_x = pick_coord();
        x.point_y = pick_coord();
        return x;
    endfunction

    // offer one transaction, then maybe end the burst with a gap
    task automatic offer(input item_t x);
        int gap;
        item       <= x;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        case (x.cmd)
            CMD_WRITE:   n_writes++;
            CMD_OVERLAP: n_overlap++;
            CMD_POINT:   n_point++;
            default:     n_unused++;
        endcase
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain();
        if (item_valid)
            item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // search count write, only while the block is idle
    task automatic set_search(input int span);
        cfg_data  <= span[CFG_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // result side: randomly chosen stall patterns, one long hold-off
    initial
    begin : result_side
        int taken;
        int cyc;
        int mode;
        bit held;
        taken = 0;
        cyc   = 0;
        mode  = 0;
        held  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                taken++;
            if (!held && taken >= 150)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            cyc++;
            if (cyc % 48 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 9) < 3);
                default: result_stall <= (cyc % 4 != 0);
            endcase
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int spans [6];
        int p;
        int k;
        spans[0] = 16;
        spans[1] = 31;
        spans[2] = 0;
        spans[3] = 1;
        spans[4] = $urandom_range(2, 15);
        spans[5] = 16;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing searched yet: every query misses
        set_search(0);
        offer(rect_item(CMD_OVERLAP, 0, -32768, -32768, 32767, 32767));
        offer(point_item(0, 0));
        offer(rect_item(CMD_UNUSED, 15, -1, -1, -1, -1));

        // fill the whole table: ties, inverted, zero width, full extent
        offer(rect_item(CMD_WRITE, 0, 0, 0, 10, 10));
        offer(rect_item(CMD_WRITE, 1, 0, 0, 10, 10));
        offer(rect_item(CMD_WRITE, 2, 5, 5, 40, 40));
        offer(rect_item(CMD_WRITE, 3, 20, 20, 10, 10));
        offer(rect_item(CMD_WRITE, 4, 100, 100, 100, 200));
        for (k = 5; k < 15; k++)
            offer(rect_item(CMD_WRITE, k, 300 + 50 * k, -200, 320 + 50 * k, -150));
        offer(rect_item(CMD_WRITE, 15, -32768, -32768, 32767, 32767));

        // count above table size saturates
        drain();
        set_search(31);
        offer(rect_item(CMD_OVERLAP, 0, 0, 0, 10, 10));
        offer(rect_item(CMD_OVERLAP, 0, 5, 5, 40, 40));
        offer(rect_item(CMD_OVERLAP, 0, -32768, -32768, 32767, 32767));
        offer(point_item(-32768, -32768));
        offer(point_item(32767, 0));
        offer(point_item(10, 10));

        // random phases, each under its own search count
        for (p = 0; p < 6; p++)
        begin
            drain();
            set_search(spans[p]);
            repeat (PHASE_ITEMS) offer(random_item());
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d table writes, %0d best-overlap queries, %0d point queries,",
                 n_writes, n_overlap, n_point);
        $display("%0d unused commands, %0d search-count settings from 0 to 31, %0d results compared",
                 n_unused, n_settings, checked);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
